### design/ttcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttcs_pkg
// Shared constants, types and helpers for the character terminal pane.
// ----------------------------------------------------------------------------
package ttcs_pkg;

    localparam int COLUMNS   = 32;
    localparam int PANE_ROWS = 24;

    localparam int COL_W     = $clog2(COLUMNS);
    localparam int ROW_W     = $clog2(PANE_ROWS);
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int MEM_DEPTH = PANE_ROWS * (2 ** COL_W);
    localparam int CHAR_W    = 7;

    // Item kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Byte codes.
    localparam logic [7:0] BYTE_CR       = 8'h0D;
    localparam logic [7:0] BYTE_LF       = 8'h0A;
    localparam logic [7:0] BYTE_BS       = 8'h08;
    localparam logic [7:0] BYTE_PRINT_LO = 8'h20;
    localparam logic [7:0] BYTE_PRINT_HI = 8'h7E;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 7'h2E;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

    // Write request to the character store.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CHAR_W-1:0] data;
    } ram_wr_t;

    // Pane row to store row through the ring pointer. The result is used only
    // with both operands below PANE_ROWS, so one conditional subtract is enough.
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                  input logic [ROW_W-1:0] pane);
        logic [ROW_W:0] sum;
        sum = {1'b0, top} + {1'b0, pane};
        if (sum >= (ROW_W+1)'(PANE_ROWS)) begin
            sum = sum - (ROW_W+1)'(PANE_ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

endpackage
`default_nettype wire

### design/ttcs_char_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttcs_char_ram
// Character store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ttcs_char_ram
    import ttcs_pkg::*;
(
    input  wire logic              aclk,
    input  wire ram_wr_t           wr,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [CHAR_W-1:0] rd_data
);

    logic [CHAR_W-1:0] mem [MEM_DEPTH];
    logic [CHAR_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read data holds until the next read is issued.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### design/text_terminal_cursor_scroll.sv
// A byte beat passes through ST_EXEC into the result register, a read beat through ST_EXEC
// and ST_RDATA, each waiting in its last state while the result register is full; a first
// store into a row blank since reset or a scroll first sweeps it to spaces in ST_CLEAR,
// column by column, through the store's single write port. One beat is in flight at a time.
// Reset (aresetn low, synchronous) homes the cursor and ring pointer and marks every row
// blank at once; there is no clearing pass, and the block takes beats right after reset.
`default_nettype none
// ----------------------------------------------------------------------------
// text_terminal_cursor_scroll
// Character terminal pane: bytes move a cursor over a ring-addressed character
// store, read beats return one cell.
// ----------------------------------------------------------------------------
module text_terminal_cursor_scroll
    import ttcs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_kind,
    input  wire logic [7:0] s_byte_in,
    input  wire logic [4:0] s_read_row,
    input  wire logic [4:0] s_read_col,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [6:0]      m_cell_char,
    output logic [4:0]      m_cursor_col,
    output logic [4:0]      m_cursor_row
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EXEC  = 4'b0010,
        ST_CLEAR = 4'b0100,
        ST_RDATA = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Cursor, ring pointer and per-row valid bits. A row whose valid bit is
    // low reads as all spaces; its store contents are stale.
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [ROW_W-1:0]     top_reg, top_next;
    logic [PANE_ROWS-1:0] row_valid_reg, row_valid_next;
    logic [COL_W-1:0]     clr_col_reg, clr_col_next;

    // Captured beat.
    logic       kind_reg;
    logic [7:0] byte_reg;
    logic [4:0] read_row_reg;
    logic [4:0] read_col_reg;

    // Read bookkeeping carried to the read data cycle.
    logic rd_ok_reg, rd_ok_next;
    logic rd_live_reg, rd_live_next;

    // Result register.
    logic              m_valid_reg;
    logic [CHAR_W-1:0] m_cell_reg;
    logic [COL_W-1:0]  m_col_reg;
    logic [ROW_W-1:0]  m_row_reg;

    logic              load_out;
    logic [CHAR_W-1:0] out_cell;
    logic              out_free;

    ram_wr_t           wr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [CHAR_W-1:0] rd_data;

    // Decode of the captured beat.
    logic              is_cr, is_lf, is_bs, is_print, needs_store;
    logic [CHAR_W-1:0] store_char;
    logic [ROW_W-1:0]  cur_prow;
    logic [COL_W-1:0]  bs_col;
    logic [COL_W:0]    inc_col;
    logic              at_bottom;
    logic              rd_in_range;
    logic [ROW_W-1:0]  rd_prow;
    logic [ROW_W-1:0]  top_inc;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    assign is_cr       = (byte_reg == BYTE_CR);
    assign is_lf       = (byte_reg == BYTE_LF);
    assign is_bs       = (byte_reg == BYTE_BS);
    assign is_print    = (byte_reg >= BYTE_PRINT_LO) && (byte_reg <= BYTE_PRINT_HI);
    assign needs_store = !is_cr && !is_lf;
    assign store_char  = is_bs ? CHAR_SPACE : (is_print ? byte_reg[CHAR_W-1:0] : CHAR_DOT);

    assign cur_prow  = phys_row(top_reg, row_reg);
    assign bs_col    = (col_reg == '0) ? col_reg : col_reg - COL_W'(1);
    assign inc_col   = {1'b0, col_reg} + (COL_W+1)'(1);
    assign at_bottom = (row_reg == ROW_W'(PANE_ROWS - 1));
    assign top_inc   = (top_reg == ROW_W'(PANE_ROWS - 1)) ? '0 : top_reg + ROW_W'(1);

    assign rd_in_range = (int'(read_row_reg) < PANE_ROWS) && (int'(read_col_reg) < COLUMNS);
    assign rd_prow     = phys_row(top_reg, ROW_W'(read_row_reg));
    assign rd_addr     = {rd_prow, COL_W'(read_col_reg)};

    always_comb begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        top_next       = top_reg;
        row_valid_next = row_valid_reg;
        clr_col_next   = clr_col_reg;
        rd_ok_next     = rd_ok_reg;
        rd_live_next   = rd_live_reg;
        wr             = '0;
        rd_en          = 1'b0;
        load_out       = 1'b0;
        out_cell       = CHAR_NONE;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                if (kind_reg == KIND_READ) begin
                    // Issue the store read; the row may be blank.
                    rd_en        = rd_in_range;
                    rd_ok_next   = rd_in_range;
                    rd_live_next = rd_in_range ? row_valid_reg[rd_prow] : 1'b0;
                    state_next   = ST_RDATA;
                end else if (needs_store && !row_valid_reg[cur_prow]) begin
                    // First store into a blank row: sweep it to spaces first.
                    clr_col_next = '0;
                    state_next   = ST_CLEAR;
                end else if (out_free) begin
                    if (needs_store) begin
                        wr.en   = 1'b1;
                        wr.addr = {cur_prow, is_bs ? bs_col : col_reg};
                        wr.data = store_char;
                    end

                    if (is_cr) begin
                        col_next = '0;
                    end else if (is_bs) begin
                        col_next = bs_col;
                    end else if (is_lf || (inc_col >= (COL_W+1)'(COLUMNS))) begin
                        // New line, scrolling on the bottom row. The old top
                        // row becomes the bottom row and goes blank.
                        col_next = '0;
                        if (at_bottom) begin
                            top_next                = top_inc;
                            row_valid_next[top_reg] = 1'b0;
                        end else begin
                            row_next = row_reg + ROW_W'(1);
                        end
                    end else begin
                        col_next = inc_col[COL_W-1:0];
                    end

                    load_out   = 1'b1;
                    out_cell   = CHAR_NONE;
                    state_next = ST_IDLE;
                end
            end

            ST_CLEAR: begin
                wr.en        = 1'b1;
                wr.addr      = {cur_prow, clr_col_reg};
                wr.data      = CHAR_SPACE;
                clr_col_next = clr_col_reg + COL_W'(1);
                if (clr_col_reg == COL_W'(COLUMNS - 1)) begin
                    row_valid_next[cur_prow] = 1'b1;
                    state_next               = ST_EXEC;
                end
            end

            ST_RDATA: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    out_cell   = !rd_ok_reg ? CHAR_NONE : (rd_live_reg ? rd_data : CHAR_SPACE);
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            top_reg       <= '0;
            row_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            top_reg       <= top_next;
            row_valid_reg <= row_valid_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge aclk) begin
        clr_col_reg <= clr_col_next;
        rd_ok_reg   <= rd_ok_next;
        rd_live_reg <= rd_live_next;
        if (s_valid && s_ready) begin
            kind_reg     <= s_kind;
            byte_reg     <= s_byte_in;
            read_row_reg <= s_read_row;
            read_col_reg <= s_read_col;
        end
        if (load_out) begin
            m_cell_reg <= out_cell;
            m_col_reg  <= col_next;
            m_row_reg  <= row_next;
        end
    end

    ttcs_char_ram u_char_ram (
        .aclk    (aclk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_valid      = m_valid_reg;
    assign m_cell_char  = m_cell_reg;
    assign m_cursor_col = 5'(m_col_reg);
    assign m_cursor_row = 5'(m_row_reg);

endmodule
`default_nettype wire

### design/ttcs_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttcs_checker
// Port-level checks for the terminal pane, bound to the top level.
// ----------------------------------------------------------------------------
module ttcs_checker
    import ttcs_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [6:0] m_cell_char,
    input wire logic [4:0] m_cursor_col,
    input wire logic [4:0] m_cursor_row
);

    // No result is pending right after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Only one beat is in work at a time.
    a_one_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on back-to-back cycles");

    // The cursor always lies inside the pane.
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_cursor_col) < COLUMNS) && (int'(m_cursor_row) < PANE_ROWS))
        else $error("cursor outside the pane");

    // Cells only ever hold printable characters; zero marks no cell.
    a_cell_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_cell_char == 7'h00) || ((m_cell_char >= 7'h20) && (m_cell_char <= 7'h7E)))
        else $error("cell character out of the printable set");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cell_char)
            && $stable(m_cursor_col) && $stable(m_cursor_row))
        else $error("stalled result changed");

endmodule

bind text_terminal_cursor_scroll ttcs_checker u_ttcs_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_cell_char  (m_cell_char),
    .m_cursor_col (m_cursor_col),
    .m_cursor_row (m_cursor_row)
);
`default_nettype wire

### tb/text_terminal_cursor_scroll_checker.sv
// ----------------------------------------------------------------------------
// Terminal pane checker
// Watches both channels of the terminal pane, keeps its own copy of the pane
// and the cursor, predicts the result of every accepted beat and compares each
// result beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module text_terminal_cursor_scroll_checker
    import ttcs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    input  logic       s_ready,
    input  logic       s_kind,
    input  logic [7:0] s_byte_in,
    input  logic [4:0] s_read_row,
    input  logic [4:0] s_read_col,

    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [6:0] m_cell_char,
    input  logic [4:0] m_cursor_col,
    input  logic [4:0] m_cursor_row,

    output int         mismatch_count,
    output int         pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [6:0] cell_char;
        logic [4:0] cursor_col;
        logic [4:0] cursor_row;
    } pane_result_t;

    // The pane is kept in display order: row 0 is the top row on screen.
    logic [CHAR_W-1:0] pane_text [PANE_ROWS][COLUMNS];
    int unsigned       cur_col;
    int unsigned       cur_row;
    pane_result_t      expected_results [$];

    initial begin
        mismatch_count  = 0;
        pending_results = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic home_pane();
        for (int r = 0; r < PANE_ROWS; r++) begin
            for (int c = 0; c < COLUMNS; c++) begin
                pane_text[r][c] = CHAR_SPACE;
            end
        end
        cur_col = 0;
        cur_row = 0;
    endtask

    // A new line on the bottom row shifts the whole pane up by one row.
    function automatic void start_new_line();
        cur_col = 0;
        if (cur_row + 1 < PANE_ROWS) begin
            cur_row++;
        end else begin
            for (int r = 0; r < PANE_ROWS - 1; r++) begin
                for (int c = 0; c < COLUMNS; c++) begin
                    pane_text[r][c] = pane_text[r+1][c];
                end
            end
            for (int c = 0; c < COLUMNS; c++) begin
                pane_text[PANE_ROWS-1][c] = CHAR_SPACE;
            end
        end
    endfunction

    function automatic pane_result_t predict_pane_beat(input logic kind,
                                                       input logic [7:0] code,
                                                       input logic [4:0] row,
                                                       input logic [4:0] col);
        pane_result_t      res;
        logic [CHAR_W-1:0] glyph;
        res = '0;
        if (kind == KIND_READ) begin
            if (row < PANE_ROWS && col < COLUMNS) begin
                res.cell_char = pane_text[row][col];
            end
        end else begin
            case (code)
                BYTE_CR: begin
                    cur_col = 0;
                end
                BYTE_LF: begin
                    start_new_line();
                end
                BYTE_BS: begin
                    if (cur_col > 0) begin
                        cur_col--;
                    end
                    pane_text[cur_row][cur_col] = CHAR_SPACE;
                end
                default: begin
                    if (code < BYTE_PRINT_LO || code > BYTE_PRINT_HI) begin
                        glyph = CHAR_DOT;
                    end else begin
                        glyph = code[6:0];
                    end
                    pane_text[cur_row][cur_col] = glyph;
                    cur_col++;
                    if (cur_col >= COLUMNS) begin
                        start_new_line();
                    end
                end
            endcase
        end
        res.cursor_col = cur_col[4:0];
        res.cursor_row = cur_row[4:0];
        return res;
    endfunction

    // Result beats are handled before the input beat of the same edge, so a
    // result can never be matched against a prediction made at that edge.
    always @(posedge aclk) begin
        pane_result_t want;
        if (!aresetn) begin
            home_pane();
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result beat with nothing expected (%h %0d %0d)",
                                              m_cell_char, m_cursor_col, m_cursor_row));
                end else begin
                    want = expected_results.pop_front();
                    if (m_cell_char !== want.cell_char) begin
                        report_mismatch($sformatf("cell_char got %h, want %h",
                                                  m_cell_char, want.cell_char));
                    end
                    if (m_cursor_col !== want.cursor_col) begin
                        report_mismatch($sformatf("cursor_col got %0d, want %0d",
                                                  m_cursor_col, want.cursor_col));
                    end
                    if (m_cursor_row !== want.cursor_row) begin
                        report_mismatch($sformatf("cursor_row got %0d, want %0d",
                                                  m_cursor_row, want.cursor_row));
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_pane_beat(s_kind, s_byte_in,
                                                             s_read_row, s_read_col));
            end
        end
        pending_results = expected_results.size();
    end

endmodule

### tb/text_terminal_cursor_scroll_tb.sv
// ----------------------------------------------------------------------------
// Terminal pane testbench
// Feeds terminal bytes and cell reads into the pane, with random gaps on the
// input and random stalls on the output, and leaves all checking to the
// checker module beside the block. Gives the verdict at the end of the run.
// ----------------------------------------------------------------------------
module text_terminal_cursor_scroll_tb;
    import ttcs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 8;
    localparam int RANDOM_BEATS    = 1250;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 2 * COLUMNS + 16;
    // CYCLE_LIMIT leaves room for the slowest correct run: every beat paying for
    // a row sweep, a full sender gap and a receiver stall.
    localparam int CYCLE_LIMIT     = 400000;

    logic       aclk = 1'b0;
    logic       aresetn;

    logic       s_valid;
    logic       s_ready;
    logic       s_kind;
    logic [7:0] s_byte_in;
    logic [4:0] s_read_row;
    logic [4:0] s_read_col;

    logic       m_valid;
    logic       m_ready;
    logic [6:0] m_cell_char;
    logic [4:0] m_cursor_col;
    logic [4:0] m_cursor_row;

    int         mismatch_count;
    int         pending_results;

    // Idle odds in percent per cycle for each side; both drop to zero for a
    // stretch in the middle of the random part.
    int         tx_idle_pct = 35;
    int         rx_idle_pct = 35;
    int         hold_off_requests = 0;
    int         beats_sent = 0;
    int         cycle_count = 0;

    // Registered at the edge, so the sender sees at the following falling
    // edge whether its beat went in, free of any race with the block.
    logic       s_fire = 1'b0;

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) begin
        s_fire <= s_valid && s_ready;
    end

    text_terminal_cursor_scroll u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_byte_in   (s_byte_in),
        .s_read_row  (s_read_row),
        .s_read_col  (s_read_col),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_cell_char (m_cell_char),
        .m_cursor_col(m_cursor_col),
        .m_cursor_row(m_cursor_row)
    );

    text_terminal_cursor_scroll_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_byte_in      (s_byte_in),
        .s_read_row     (s_read_row),
        .s_read_col     (s_read_col),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cell_char    (m_cell_char),
        .m_cursor_col   (m_cursor_col),
        .m_cursor_row   (m_cursor_row),
        .mismatch_count (mismatch_count),
        .pending_results(pending_results)
    );

    // Offers one beat at a falling edge and holds it until it is taken. Each
    // cycle before the beat may be an idle one, so gaps land on every phase of
    // the block's work. On return valid is still high with the old payload;
    // the caller either offers the next beat or lowers valid itself.
    task automatic offer_beat(input logic kind, input logic [7:0] code,
                              input logic [4:0] row, input logic [4:0] col);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid    = 1'b1;
        s_kind     = kind;
        s_byte_in  = code;
        s_read_row = row;
        s_read_col = col;
        @(negedge aclk);
        while (!s_fire) begin
            @(negedge aclk);
        end
        beats_sent++;
    endtask

    // Fields that a beat does not use still carry random values, so that
    // every bit of every field toggles.
    task automatic send_byte(input logic [7:0] code);
        offer_beat(KIND_BYTE, code, 5'($urandom_range(31)), 5'($urandom_range(31)));
    endtask

    task automatic send_read(input int row, input int col);
        offer_beat(KIND_READ, 8'($urandom_range(255)), 5'(row), 5'(col));
    endtask

    // Most reads land on the pane; about one in ten asks for a row past the
    // bottom, which must return no character.
    task automatic send_random_read();
        if ($urandom_range(9) == 0) begin
            send_read($urandom_range(31, PANE_ROWS), $urandom_range(31));
        end else begin
            send_read($urandom_range(PANE_ROWS - 1), $urandom_range(31));
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request. The hold-off
    // is counted here, so the sender keeps offering beats meanwhile and the
    // block fills up and has to stall its input.
    initial begin
        int holds_served;
        holds_served = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_requests != holds_served) begin
                holds_served++;
                m_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end
            m_ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        int  pick;
        int  run_len;
        int  random_start;
        bit  held_off;
        bit  paused;

        held_off   = 1'b0;
        paused     = 1'b0;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_kind     = KIND_BYTE;
        s_byte_in  = '0;
        s_read_row = '0;
        s_read_col = '0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;

        // Directed part. The pane is blank after reset, so the corner reads
        // return spaces, and the reads past the bottom row return nothing.
        send_read(0, 0);
        send_read(PANE_ROWS - 1, COLUMNS - 1);
        send_read(PANE_ROWS, 0);
        send_read(31, 31);
        // Printable extremes, then DEL, high bytes and low control bytes,
        // all of which must show up as a dot.
        send_byte(8'h41);
        send_byte(BYTE_PRINT_LO);
        send_byte(BYTE_PRINT_HI);
        send_byte(8'h7F);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h00);
        send_byte(8'h1F);
        send_read(0, 0);
        send_read(0, 3);
        // Backspace in the middle of a line, then carriage return and a
        // backspace at column zero, which still blanks the cell under it.
        send_byte(BYTE_BS);
        send_read(0, 7);
        send_byte(BYTE_CR);
        send_byte(BYTE_BS);
        send_read(0, 0);
        send_byte(BYTE_LF);
        send_byte(8'h5A);
        send_read(1, 0);
        send_read(0, COLUMNS - 1);

        // Random part. Most of it is lines of text ended by CR LF, which
        // drives the cursor to the bottom row and keeps the pane scrolling;
        // long lines wrap on their own. The rest is reads, runs of line feeds
        // and backspaces, lone carriage returns and raw noise bytes.
        random_start = beats_sent;
        while (beats_sent - random_start < RANDOM_BEATS) begin
            // A stretch in the middle with no idling on either side.
            if (beats_sent - random_start >= 500 && beats_sent - random_start < 700) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                tx_idle_pct = 35;
                rx_idle_pct = 35;
            end

            if (!held_off && beats_sent - random_start >= 200) begin
                held_off = 1'b1;
                hold_off_requests++;
            end

            // Once, the sender stops until every result is back.
            if (!paused && beats_sent - random_start >= 900) begin
                paused  = 1'b1;
                s_valid = 1'b0;
                while (pending_results != 0) begin
                    @(negedge aclk);
                end
            end

            pick = $urandom_range(99);
            if (pick < 45) begin
                if ($urandom_range(9) == 0) begin
                    run_len = $urandom_range(COLUMNS + 8, COLUMNS + 1);
                end else begin
                    run_len = $urandom_range(20, 1);
                end
                repeat (run_len) begin
                    send_byte(8'($urandom_range(BYTE_PRINT_HI, BYTE_PRINT_LO)));
                end
                if ($urandom_range(3) != 0) begin
                    send_byte(BYTE_CR);
                    send_byte(BYTE_LF);
                end
            end else if (pick < 70) begin
                repeat ($urandom_range(3, 1)) begin
                    send_random_read();
                end
            end else if (pick < 80) begin
                repeat ($urandom_range(4, 1)) begin
                    send_byte(BYTE_LF);
                end
            end else if (pick < 88) begin
                repeat ($urandom_range(3, 1)) begin
                    send_byte(BYTE_BS);
                end
            end else if (pick < 93) begin
                send_byte(BYTE_CR);
            end else begin
                send_byte(8'($urandom_range(255)));
            end
        end

        // Drain: wait for every expected result, then a little longer so that
        // a stray extra result beat would still be caught.
        s_valid = 1'b0;
        while (pending_results != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
